// ===== hw/rtl/tpbs_pkg.sv =====
// Package for the two-job burst scheduler.
// Holds the job phase codes, policy codes and register indexes; no dependencies.
package tpbs_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 8;

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_RUN   = 2'd1,
    PH_WAIT  = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    POL_FCFS = 2'd0,
    POL_SJF  = 2'd1,
    POL_RR   = 2'd2,
    POL_RSVD = 2'd3
  } policy_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_POLICY      = 3'd0,
    REG_SLICE       = 3'd1,
    REG_JOB1_FIRST  = 3'd2,
    REG_JOB1_IO     = 3'd3,
    REG_JOB1_SECOND = 3'd4,
    REG_JOB2_FIRST  = 3'd5,
    REG_JOB2_IO     = 3'd6,
    REG_JOB2_SECOND = 3'd7
  } reg_idx_e;

  localparam logic [1:0]              RstPolicy     = 2'd0;
  localparam logic [CfgDataWidth-1:0] RstSlice      = 8'd4;
  localparam logic [CfgDataWidth-1:0] RstFirstBurst = 8'd1;
  localparam logic [CfgDataWidth-1:0] RstIoBurst    = 8'd0;
  localparam logic [CfgDataWidth-1:0] RstSecBurst   = 8'd1;

endpackage

// ===== hw/rtl/two_process_burst_scheduler.sv =====
// Two-job burst scheduler: one scheduling tick per input transaction.
// Depends on tpbs_pkg for phase, policy and register index codes.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | restart_i
//  out     | output    | out_valid_o/out_ready_i| job1_status_o, job2_status_o,
//          |           |                        | all_finished_o
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One tick per clock while in_ready_o is high: the tick logic between the state
// and result registers completes on accept; the result appears on the next cycle.
// Reset loads the default registers and counters and empties the result register.
// A new transaction is taken while the result register is empty or being drained.
module two_process_burst_scheduler #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpbs_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [tpbs_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        job1_status_o,
  output logic [1:0]                        job2_status_o,
  output logic                              all_finished_o
);
  import tpbs_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;

  logic [1:0]              policy_q;
  logic [CfgDataWidth-1:0] slice_cfg_q, j1_first_q, j1_io_q, j1_sec_q;
  logic [CfgDataWidth-1:0] j2_first_q, j2_io_q, j2_sec_q;

  phase_e          p1_q, p2_q, p1_d, p2_d;
  logic [CW-1:0]   c1_q, c2_q, io1_q, io2_q, sl_q;
  logic [CW-1:0]   c1_d, c2_d, io1_d, io2_d, sl_d;
  logic [CW-1:0]   quantum;
  logic            rr, sjf;
  phase_e          st1, st2;

  logic            out_valid_q;
  logic [1:0]      st1_q, st2_q;
  logic            fin_q;
  logic            accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= RstPolicy;
      slice_cfg_q <= RstSlice;
      j1_first_q  <= RstFirstBurst;
      j1_io_q     <= RstIoBurst;
      j1_sec_q    <= RstSecBurst;
      j2_first_q  <= RstFirstBurst;
      j2_io_q     <= RstIoBurst;
      j2_sec_q    <= RstSecBurst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_POLICY:      policy_q    <= cfg_data_i[1:0];
        REG_SLICE:       slice_cfg_q <= cfg_data_i;
        REG_JOB1_FIRST:  j1_first_q  <= cfg_data_i;
        REG_JOB1_IO:     j1_io_q     <= cfg_data_i;
        REG_JOB1_SECOND: j1_sec_q    <= cfg_data_i;
        REG_JOB2_FIRST:  j2_first_q  <= cfg_data_i;
        REG_JOB2_IO:     j2_io_q     <= cfg_data_i;
        REG_JOB2_SECOND: j2_sec_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign quantum = CW'(slice_cfg_q);
  assign rr      = (policy_e'(policy_q) == POL_RR);
  assign sjf     = (policy_e'(policy_q) == POL_SJF);

  always_comb begin
    p1_d  = p1_q;
    p2_d  = p2_q;
    c1_d  = c1_q;
    c2_d  = c2_q;
    io1_d = io1_q;
    io2_d = io2_q;
    sl_d  = sl_q;

    if (restart_i) begin
      p1_d  = PH_READY;
      p2_d  = PH_READY;
      c1_d  = CW'(j1_first_q);
      io1_d = CW'(j1_io_q);
      c2_d  = CW'(j2_first_q);
      io2_d = CW'(j2_io_q);
      sl_d  = quantum;
    end

    if (p1_d == PH_RUN && c1_d == '0) begin
      p1_d = (io1_d == '0) ? PH_DONE : PH_WAIT;
    end else if (p2_d == PH_RUN && c2_d == '0) begin
      p2_d = (io2_d == '0) ? PH_DONE : PH_WAIT;
    end

    if (rr) begin
      if (p1_d == PH_RUN && sl_d == '0) begin
        p1_d = PH_READY;
        if (p2_d == PH_READY) begin
          p2_d = PH_RUN;
          sl_d = quantum;
        end
      end
      if (p2_d == PH_RUN && sl_d == '0) begin
        p2_d = PH_READY;
        if (p1_d == PH_READY) begin
          p1_d = PH_RUN;
          sl_d = quantum;
        end
      end
    end

    if (p1_d == PH_WAIT && io1_d == '0) begin
      p1_d = PH_READY;
      c1_d = CW'(j1_sec_q);
    end
    if (p2_d == PH_WAIT && io2_d == '0) begin
      p2_d = PH_READY;
      c2_d = CW'(j2_sec_q);
    end

    if (p1_d == PH_READY && p2_d == PH_READY) begin
      if (sjf && c2_d < c1_d) begin
        p2_d = PH_RUN;
      end else begin
        p1_d = PH_RUN;
      end
      if (rr) begin
        sl_d = quantum;
      end
    end else if (p1_d == PH_READY && p2_d != PH_RUN) begin
      p1_d = PH_RUN;
      if (rr) begin
        sl_d = quantum;
      end
    end else if (p2_d == PH_READY && p1_d != PH_RUN) begin
      p2_d = PH_RUN;
      if (rr) begin
        sl_d = quantum;
      end
    end

    st1 = p1_d;
    st2 = p2_d;

    if (sl_d != '0) begin
      sl_d = sl_d - 1'b1;
    end
    if (p1_d == PH_RUN && c1_d != '0) begin
      c1_d = c1_d - 1'b1;
    end
    if (p1_d == PH_WAIT && io1_d != '0) begin
      io1_d = io1_d - 1'b1;
    end
    if (p2_d == PH_RUN && c2_d != '0) begin
      c2_d = c2_d - 1'b1;
    end
    if (p2_d == PH_WAIT && io2_d != '0) begin
      io2_d = io2_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q        <= PH_READY;
      p2_q        <= PH_READY;
      c1_q        <= CW'(RstFirstBurst);
      c2_q        <= CW'(RstFirstBurst);
      io1_q       <= CW'(RstIoBurst);
      io2_q       <= CW'(RstIoBurst);
      sl_q        <= CW'(RstSlice);
      out_valid_q <= 1'b0;
    end else if (accept) begin
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      c1_q        <= c1_d;
      c2_q        <= c2_d;
      io1_q       <= io1_d;
      io2_q       <= io2_d;
      sl_q        <= sl_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st1_q <= st1;
      st2_q <= st2;
      fin_q <= (st1 == PH_DONE) && (st2 == PH_DONE);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign job1_status_o  = st1_q;
  assign job2_status_o  = st2_q;
  assign all_finished_o = fin_q;

endmodule

// ===== verif/tb_two_process_burst_scheduler.sv =====
// Testbench for two_process_burst_scheduler: drives scheduler ticks and register writes,
// checks each tick's status against an in-bench predictor or a pinned expectation.
// Depends on tpbs_pkg and the two_process_burst_scheduler RTL.
`timescale 1ns / 1ps

module tb_two_process_burst_scheduler;
  import tpbs_pkg::*;

  typedef struct packed {
    phase_e job1;
    phase_e job2;
    logic   fin;
  } sched_status_t;

  typedef enum logic {
    ROW_WRITE = 1'b0,
    ROW_TICK  = 1'b1
  } row_kind_e;

  typedef struct {
    row_kind_e     kind;
    reg_idx_e      idx;
    logic [7:0]    data;
    logic          restart;
    logic          pinned;
    sched_status_t want;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       restart_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] job1_status_o;
  logic [1:0] job2_status_o;
  logic       all_finished_o;

  two_process_burst_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .job1_status_o  (job1_status_o),
    .job2_status_o  (job2_status_o),
    .all_finished_o (all_finished_o)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0]    cfg_shadow [8];
  phase_e        ph1, ph2;
  logic [7:0]    cpu1, cpu2, io1, io2, slice_cnt;
  sched_status_t status_q [$];
  int            mismatch_cnt = 0;
  int            sent_cnt = 0;
  int            snd_idle_pct = 26;
  int            rcv_idle_pct = 82;
  logic          pin_en = 1'b0;
  sched_status_t pin_val;
  dir_row_t      dir_tab [$];

  function automatic void reload_jobs();
    ph1       = PH_READY;
    ph2       = PH_READY;
    cpu1      = cfg_shadow[REG_JOB1_FIRST];
    io1       = cfg_shadow[REG_JOB1_IO];
    cpu2      = cfg_shadow[REG_JOB2_FIRST];
    io2       = cfg_shadow[REG_JOB2_IO];
    slice_cnt = cfg_shadow[REG_SLICE];
  endfunction

  function automatic sched_status_t sched_tick(input logic restart);
    policy_e       mode;
    logic [7:0]    quantum;
    logic          rr;
    sched_status_t r;
    mode    = policy_e'(cfg_shadow[REG_POLICY][1:0]);
    quantum = cfg_shadow[REG_SLICE];
    rr      = (mode == POL_RR);
    if (restart) reload_jobs();

    if (ph1 == PH_RUN && cpu1 == 0) begin
      ph1 = (io1 == 0) ? PH_DONE : PH_WAIT;
    end else if (ph2 == PH_RUN && cpu2 == 0) begin
      ph2 = (io2 == 0) ? PH_DONE : PH_WAIT;
    end

    if (rr) begin
      if (ph1 == PH_RUN && slice_cnt == 0) begin
        ph1 = PH_READY;
        if (ph2 == PH_READY) begin
          ph2       = PH_RUN;
          slice_cnt = quantum;
        end
      end
      if (ph2 == PH_RUN && slice_cnt == 0) begin
        ph2 = PH_READY;
        if (ph1 == PH_READY) begin
          ph1       = PH_RUN;
          slice_cnt = quantum;
        end
      end
    end

    if (ph1 == PH_WAIT && io1 == 0) begin
      ph1  = PH_READY;
      cpu1 = cfg_shadow[REG_JOB1_SECOND];
    end
    if (ph2 == PH_WAIT && io2 == 0) begin
      ph2  = PH_READY;
      cpu2 = cfg_shadow[REG_JOB2_SECOND];
    end

    if (ph1 == PH_READY && ph2 == PH_READY) begin
      if (mode == POL_SJF && cpu2 < cpu1) ph2 = PH_RUN;
      else ph1 = PH_RUN;
      if (rr) slice_cnt = quantum;
    end else if (ph1 == PH_READY && ph2 != PH_RUN) begin
      ph1 = PH_RUN;
      if (rr) slice_cnt = quantum;
    end else if (ph2 == PH_READY && ph1 != PH_RUN) begin
      ph2 = PH_RUN;
      if (rr) slice_cnt = quantum;
    end

    r.job1 = ph1;
    r.job2 = ph2;
    r.fin  = (ph1 == PH_DONE && ph2 == PH_DONE);

    if (slice_cnt != 0) slice_cnt--;
    if (ph1 == PH_RUN && cpu1 != 0) cpu1--;
    if (ph1 == PH_WAIT && io1 != 0) io1--;
    if (ph2 == PH_RUN && cpu2 != 0) cpu2--;
    if (ph2 == PH_WAIT && io2 != 0) io2--;
    return r;
  endfunction

  always @(posedge clk_i) begin : monitor
    sched_status_t want;
    sched_status_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        cfg_shadow[cfg_idx_i] = (cfg_idx_i == REG_POLICY) ? {6'd0, cfg_data_i[1:0]} : cfg_data_i;
      end
      if (out_valid_o && out_ready_i) begin
        got.job1 = phase_e'(job1_status_o);
        got.job2 = phase_e'(job2_status_o);
        got.fin  = all_finished_o;
        if (status_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: unexpected transaction job1=%0d job2=%0d fin=%0d",
                     $realtime, got.job1, got.job2, got.fin);
          end
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display({"%0t: mismatch exp job1=%0d job2=%0d fin=%0d,",
                        " got job1=%0d job2=%0d fin=%0d"},
                       $realtime, want.job1, want.job2, want.fin, got.job1, got.job2, got.fin);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = sched_tick(restart_i);
        status_q.push_back(pin_en ? pin_val : want);
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= rcv_idle_pct);
  end

  function automatic void add_write(input reg_idx_e idx, input logic [7:0] data);
    dir_row_t row;
    row.kind    = ROW_WRITE;
    row.idx     = idx;
    row.data    = data;
    row.restart = 1'b0;
    row.pinned  = 1'b0;
    row.want    = '0;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_tick(input logic restart);
    dir_row_t row;
    row.kind    = ROW_TICK;
    row.idx     = REG_POLICY;
    row.data    = '0;
    row.restart = restart;
    row.pinned  = 1'b0;
    row.want    = '0;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_tick_exp(input logic restart, input phase_e j1, input phase_e j2,
                                       input logic fin);
    dir_row_t row;
    row.kind      = ROW_TICK;
    row.idx       = REG_POLICY;
    row.data      = '0;
    row.restart   = restart;
    row.pinned    = 1'b1;
    row.want.job1 = j1;
    row.want.job2 = j2;
    row.want.fin  = fin;
    dir_tab.push_back(row);
  endfunction

  task automatic send_tick(input logic restart, input logic pinned, input sched_status_t want);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      restart_i  = 1'($urandom_range(1));
      pin_en     = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    restart_i  = restart;
    pin_en     = pinned;
    pin_val    = want;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    pin_en     = 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  function automatic logic [7:0] rand_reg_value(input reg_idx_e idx);
    int pick;
    pick = $urandom_range(19);
    case (idx)
      REG_POLICY: return {6'd0, 2'($urandom_range(3))};
      REG_SLICE: begin
        if (pick == 0) return 8'd255;
        if (pick < 4) return 8'd1;
        return 8'($urandom_range(2, 6));
      end
      REG_JOB1_IO, REG_JOB2_IO: begin
        if (pick == 0) return 8'd255;
        if (pick < 7) return 8'd0;
        return 8'($urandom_range(1, 5));
      end
      default: begin
        if (pick == 0) return 8'd255;
        return 8'($urandom_range(1, 6));
      end
    endcase
  endfunction

  task automatic run_segment();
    int n;
    wait_drained();
    for (int r = 0; r < 8; r++) begin
      if ($urandom_range(3) != 0) write_reg(reg_idx_e'(r), rand_reg_value(reg_idx_e'(r)));
    end
    n = $urandom_range(10, 40);
    for (int k = 0; k < n; k++) begin
      send_tick((k == 0) ? ($urandom_range(4) != 0) : ($urandom_range(39) == 0), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int start;
    cfg_shadow[REG_POLICY]      = {6'd0, RstPolicy};
    cfg_shadow[REG_SLICE]       = RstSlice;
    cfg_shadow[REG_JOB1_FIRST]  = RstFirstBurst;
    cfg_shadow[REG_JOB1_IO]     = RstIoBurst;
    cfg_shadow[REG_JOB1_SECOND] = RstSecBurst;
    cfg_shadow[REG_JOB2_FIRST]  = RstFirstBurst;
    cfg_shadow[REG_JOB2_IO]     = RstIoBurst;
    cfg_shadow[REG_JOB2_SECOND] = RstSecBurst;
    reload_jobs();

    add_tick_exp(1'b0, PH_RUN, PH_READY, 1'b0);
    add_tick_exp(1'b0, PH_DONE, PH_RUN, 1'b0);
    add_tick_exp(1'b0, PH_DONE, PH_DONE, 1'b1);
    add_tick_exp(1'b0, PH_DONE, PH_DONE, 1'b1);
    add_tick_exp(1'b1, PH_RUN, PH_READY, 1'b0);
    add_write(REG_POLICY, {6'd0, POL_SJF});
    add_write(REG_JOB1_FIRST, 8'd3);
    add_write(REG_JOB2_FIRST, 8'd2);
    add_tick_exp(1'b1, PH_READY, PH_RUN, 1'b0);
    repeat (3) add_tick(1'b0);
    add_write(REG_POLICY, {6'd0, POL_RR});
    add_write(REG_SLICE, 8'd1);
    add_write(REG_JOB1_IO, 8'd2);
    add_write(REG_JOB2_IO, 8'd255);
    add_write(REG_JOB1_SECOND, 8'd255);
    add_write(REG_JOB2_SECOND, 8'd1);
    add_tick(1'b1);
    repeat (5) add_tick(1'b0);
    add_write(REG_POLICY, {6'd0, POL_RSVD});
    add_write(REG_SLICE, 8'd255);
    add_write(REG_JOB1_FIRST, 8'd255);
    add_write(REG_JOB2_FIRST, 8'd255);
    add_write(REG_JOB1_IO, 8'd0);
    add_write(REG_JOB2_IO, 8'd0);
    add_tick(1'b1);
    repeat (2) add_tick(1'b0);
    add_write(REG_JOB2_FIRST, 8'd1);
    repeat (2) add_tick(1'b0);
    add_write(REG_POLICY, {6'd0, POL_FCFS});
    add_tick(1'b1);
    add_write(REG_POLICY, {6'd0, POL_RR});
    add_write(REG_SLICE, 8'd1);
    add_write(REG_JOB1_FIRST, 8'd1);
    add_tick(1'b1);
    repeat (3) add_tick(1'b0);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        if (i == 0 || dir_tab[i-1].kind != ROW_WRITE) wait_drained();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_tick(dir_tab[i].restart, dir_tab[i].pinned, dir_tab[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 26;
          rcv_idle_pct = 82;
        end
        1: begin
          snd_idle_pct = 82;
          rcv_idle_pct = 26;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      start = sent_cnt;
      while (sent_cnt - start < 200) run_segment();
    end

    in_valid_i = 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    if (mismatch_cnt == 0 && status_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
